[design/jsu_pkg.sv]
`default_nettype none

package jsu_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 16;
    localparam int FIELD_COUNT_WIDTH = 16;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [2:0] HEX_DIGITS = 3'd4;

    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_NO_QUOTE     = 3'd1,
        ERR_BAD_ESCAPE   = 3'd2,
        ERR_BAD_HEX      = 3'd3,
        ERR_OVER_RANGE   = 3'd4,
        ERR_UNTERMINATED = 3'd5
    } err_t;

    typedef struct packed {
        kind_t                        kind;
        logic [7:0]                   data_byte;
        err_t                         error_code;
        logic [FIELD_COUNT_WIDTH-1:0] decoded_count;
        logic [FIELD_COUNT_WIDTH-1:0] consumed_count;
    } result_t;

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(b - 8'h30)};
        end
        else if (b inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        else if (b inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/json_string_unescaper.sv]
// Decodes JSON quoted strings at one source byte per clock cycle while the
// output is not stalled. Each accepted byte goes into an input register and is
// decoded, once the output slot is free, into the result register, so a new
// byte is taken every cycle while the result side keeps up; the decode
// of the scan state bounds the rate. A string starts with the
// opening quote; plain bytes and finished escapes give a data item, the
// backslash and the bytes of a \u escape give none until the escape ends, the
// closing quote gives a done item with the decoded and consumed counts, and
// every failure gives an error item and returns the block to waiting for an
// opening quote. Counts saturate at 2**COUNT_WIDTH - 1 and their low 16 bits
// are reported.
`default_nettype none

module json_string_unescaper
    import jsu_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [2:0]       error_code,
    output logic [15:0]      decoded_count,
    output logic [15:0]      consumed_count
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       slot_free;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign fire = item_valid && slot_free;

    jsu_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .advance    (fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    jsu_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item_byte (item_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    jsu_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind           = out_res.kind;
    assign data_byte      = out_res.data_byte;
    assign error_code     = out_res.error_code;
    assign decoded_count  = out_res.decoded_count;
    assign consumed_count = out_res.consumed_count;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DATA |->
            error_code == ERR_NONE && decoded_count == 16'd0 && consumed_count == 16'd0)
    else $error("data item carries status fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERR |-> error_code != ERR_NONE && data_byte == 8'd0)
    else $error("error item without an error code");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |->
            consumed_count >= 16'd2 && decoded_count <= consumed_count)
    else $error("done item with inconsistent counts");

endmodule

`default_nettype wire

[design/jsu_in_stage.sv]
`default_nettype none

module jsu_in_stage
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       advance,
    output logic            item_valid,
    output logic [7:0]      item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

[design/jsu_core.sv]
`default_nettype none

module jsu_core
    import jsu_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] item_byte,
    output logic            res_valid,
    output result_t         res
);

    mode_t                  mode_reg, mode_next;
    logic [15:0]            hex_reg, hex_next;
    logic [2:0]             digits_reg, digits_next;
    logic [COUNT_WIDTH-1:0] dec_reg, dec_next, dec_inc;
    logic [COUNT_WIDTH-1:0] con_reg, con_next, con_inc;
    logic [4:0]             hd;
    logic                   put_en, err_en, done_en;
    logic [7:0]             put_val;
    err_t                   err_code;

    assign hd      = hex_digit(item_byte);
    assign dec_inc = (&dec_reg) ? dec_reg : dec_reg + COUNT_WIDTH'(1);
    assign con_inc = (&con_reg) ? con_reg : con_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        mode_next   = mode_reg;
        hex_next    = hex_reg;
        digits_next = digits_reg;
        dec_next    = dec_reg;
        con_next    = con_reg;
        put_en      = 1'b0;
        put_val     = 8'd0;
        err_en      = 1'b0;
        err_code    = ERR_NONE;
        done_en     = 1'b0;
        case (mode_reg)
            MODE_BODY:
            begin
                if (item_byte == CH_NUL)
                begin
                    err_en   = 1'b1;
                    err_code = ERR_UNTERMINATED;
                end
                else
                begin
                    con_next = con_inc;
                    if (item_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_WAIT;
                        done_en   = 1'b1;
                    end
                    else if (item_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        put_en  = 1'b1;
                        put_val = item_byte;
                    end
                end
            end
            MODE_ESC:
            begin
                if (item_byte == CH_NUL)
                begin
                    err_en   = 1'b1;
                    err_code = ERR_UNTERMINATED;
                end
                else
                begin
                    con_next = con_inc;
                    put_en   = 1'b1;
                    case (item_byte)
                        CH_QUOTE:     put_val = CH_QUOTE;
                        CH_BACKSLASH: put_val = CH_BACKSLASH;
                        CH_SLASH:     put_val = CH_SLASH;
                        CH_B:         put_val = BYTE_BS;
                        CH_F:         put_val = BYTE_FF;
                        CH_N:         put_val = BYTE_LF;
                        CH_R:         put_val = BYTE_CR;
                        CH_T:         put_val = BYTE_TAB;
                        CH_U:
                        begin
                            put_en      = 1'b0;
                            hex_next    = 16'd0;
                            digits_next = 3'd0;
                            mode_next   = MODE_HEX;
                        end
                        default:
                        begin
                            put_en   = 1'b0;
                            err_en   = 1'b1;
                            err_code = ERR_BAD_ESCAPE;
                        end
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (item_byte == CH_NUL)
                begin
                    err_en   = 1'b1;
                    err_code = ERR_UNTERMINATED;
                end
                else if (!hd[4])
                begin
                    err_en   = 1'b1;
                    err_code = ERR_BAD_HEX;
                end
                else
                begin
                    con_next    = con_inc;
                    hex_next    = {hex_reg[11:0], hd[3:0]};
                    digits_next = digits_reg + 3'd1;
                    if (digits_next == HEX_DIGITS)
                    begin
                        if (hex_next[15:8] != 8'd0)
                        begin
                            err_en   = 1'b1;
                            err_code = ERR_OVER_RANGE;
                        end
                        else
                        begin
                            put_en  = 1'b1;
                            put_val = hex_next[7:0];
                        end
                    end
                end
            end
            default:
            begin
                if (item_byte != CH_QUOTE)
                begin
                    err_en   = 1'b1;
                    err_code = ERR_NO_QUOTE;
                end
                else
                begin
                    mode_next   = MODE_BODY;
                    dec_next    = '0;
                    con_next    = COUNT_WIDTH'(1);
                    hex_next    = 16'd0;
                    digits_next = 3'd0;
                end
            end
        endcase

        if (put_en)
        begin
            dec_next  = dec_inc;
            mode_next = MODE_BODY;
        end
        if (err_en)
        begin
            mode_next = MODE_WAIT;
        end

        res_valid = put_en || err_en || done_en;
        res       = '0;
        if (put_en)
        begin
            res.kind      = KIND_DATA;
            res.data_byte = put_val;
        end
        else if (err_en)
        begin
            res.kind       = KIND_ERR;
            res.error_code = err_code;
        end
        else if (done_en)
        begin
            res.kind           = KIND_DONE;
            res.decoded_count  = FIELD_COUNT_WIDTH'(dec_reg);
            res.consumed_count = FIELD_COUNT_WIDTH'(con_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_WAIT;
            hex_reg    <= 16'd0;
            digits_reg <= 3'd0;
            dec_reg    <= '0;
            con_reg    <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            hex_reg    <= hex_next;
            digits_reg <= digits_next;
            dec_reg    <= dec_next;
            con_reg    <= con_next;
        end
    end

endmodule

`default_nettype wire

[design/jsu_out_stage.sv]
`default_nettype none

module jsu_out_stage
    import jsu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire result_t  res,
    output logic          slot_free,
    output logic          out_valid,
    input  wire logic     out_stall,
    output result_t       out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign slot_free = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

[sim/json_string_unescaper_tb.sv]
`timescale 1ns / 1ps

import jsu_pkg::*;

class unescape_tracker;
    result_t     pending_outputs[$];
    mode_t       scan;
    logic [15:0] hex_acc;
    logic [2:0]  hex_seen;
    logic [15:0] decoded_total;
    logic [15:0] consumed_total;
    int          mismatches;

    function new();
        scan = MODE_WAIT;
        hex_acc = 16'h0000;
        hex_seen = 3'd0;
        decoded_total = 16'h0000;
        consumed_total = 16'h0000;
        mismatches = 0;
    endfunction

    function logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void queue_output(input kind_t k, input logic [7:0] d, input err_t e,
                               input logic [15:0] dc, input logic [15:0] cc);
        result_t r;
        r.kind = k;
        r.data_byte = d;
        r.error_code = e;
        r.decoded_count = dc;
        r.consumed_count = cc;
        pending_outputs.push_back(r);
    endfunction

    function void abort_string(input err_t e);
        scan = MODE_WAIT;
        queue_output(KIND_ERR, 8'h00, e, 16'h0000, 16'h0000);
    endfunction

    function void decoded_char(input logic [7:0] d);
        decoded_total = bump(decoded_total);
        scan = MODE_BODY;
        queue_output(KIND_DATA, d, ERR_NONE, 16'h0000, 16'h0000);
    endfunction

    function void take_source_byte(input logic [7:0] b);
        int digit;
        digit = -1;
        if (b >= 8'h30 && b <= 8'h39) digit = int'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) digit = int'(b - 8'h61) + 10;
        else if (b >= 8'h41 && b <= 8'h46) digit = int'(b - 8'h41) + 10;
        case (scan)
            MODE_BODY:
            begin
                if (b == CH_NUL) abort_string(ERR_UNTERMINATED);
                else
                begin
                    consumed_total = bump(consumed_total);
                    if (b == CH_QUOTE)
                    begin
                        scan = MODE_WAIT;
                        queue_output(KIND_DONE, 8'h00, ERR_NONE, decoded_total,
                                     consumed_total);
                    end
                    else if (b == CH_BACKSLASH) scan = MODE_ESC;
                    else decoded_char(b);
                end
            end
            MODE_ESC:
            begin
                if (b == CH_NUL) abort_string(ERR_UNTERMINATED);
                else
                begin
                    consumed_total = bump(consumed_total);
                    case (b)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: decoded_char(b);
                        CH_B: decoded_char(BYTE_BS);
                        CH_F: decoded_char(BYTE_FF);
                        CH_N: decoded_char(BYTE_LF);
                        CH_R: decoded_char(BYTE_CR);
                        CH_T: decoded_char(BYTE_TAB);
                        CH_U:
                        begin
                            hex_acc = 16'h0000;
                            hex_seen = 3'd0;
                            scan = MODE_HEX;
                        end
                        default: abort_string(ERR_BAD_ESCAPE);
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (b == CH_NUL) abort_string(ERR_UNTERMINATED);
                else if (digit < 0) abort_string(ERR_BAD_HEX);
                else
                begin
                    consumed_total = bump(consumed_total);
                    hex_acc = {hex_acc[11:0], digit[3:0]};
                    hex_seen = hex_seen + 3'd1;
                    if (hex_seen == HEX_DIGITS)
                    begin
                        if (hex_acc > 16'h00FF) abort_string(ERR_OVER_RANGE);
                        else decoded_char(hex_acc[7:0]);
                    end
                end
            end
            default:
            begin
                if (b != CH_QUOTE)
                begin
                    queue_output(KIND_ERR, 8'h00, ERR_NO_QUOTE, 16'h0000, 16'h0000);
                end
                else
                begin
                    scan = MODE_BODY;
                    decoded_total = 16'h0000;
                    consumed_total = 16'h0001;
                    hex_acc = 16'h0000;
                    hex_seen = 3'd0;
                end
            end
        endcase
    endfunction

    function void report(input string field, input logic [15:0] want,
                         input logic [15:0] got);
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void compare_output(input result_t got);
        result_t want;
        if (pending_outputs.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected item: expected none, actual kind %0d data %0d",
                     $time, got.kind, got.data_byte);
            return;
        end
        want = pending_outputs.pop_front();
        if (got.kind !== want.kind) report("kind", 16'(want.kind), 16'(got.kind));
        if (got.data_byte !== want.data_byte)
            report("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        if (got.error_code !== want.error_code)
            report("error_code", 16'(want.error_code), 16'(got.error_code));
        if (got.decoded_count !== want.decoded_count)
            report("decoded_count", want.decoded_count, got.decoded_count);
        if (got.consumed_count !== want.consumed_count)
            report("consumed_count", want.consumed_count, got.consumed_count);
    endfunction
endclass

module json_string_unescaper_tb;

    localparam int STUCK_LIMIT = 4000;

    typedef logic [7:0] byte_list_t[$];

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [15:0] decoded_count;
    logic [15:0] consumed_count;

    unescape_tracker tracker = new();
    bit              idle_on = 1'b1;
    int              fed;
    int              stuck_cycles;

    json_string_unescaper uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .error_code     (error_code),
        .decoded_count  (decoded_count),
        .consumed_count (consumed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    task automatic feed(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte = b;
        do @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.take_source_byte(b);
        fed++;
        @(negedge clk);
    endtask

    task automatic feed_hex_escape(input logic [15:0] v);
        feed(CH_BACKSLASH);
        feed(CH_U);
        for (int i = 3; i >= 0; i--) feed(hex_char(v[i*4 +: 4]));
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (tracker.pending_outputs.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // One quoted string with random content, sometimes cut short by a malformed item.
    task automatic random_string();
        int         len;
        int         r;
        int         brk;
        logic [7:0] b;
        logic [7:0] letters[8];
        letters = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        feed(CH_QUOTE);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 60) feed(plain_byte());
            else if (r < 85)
            begin
                feed(CH_BACKSLASH);
                feed(letters[3'($urandom_range(0, 7))]);
            end
            else feed_hex_escape(16'($urandom_range(0, 255)));
        end
        brk = $urandom_range(0, 99);
        if (brk >= 12) feed(CH_QUOTE);
        else
        begin
            case (brk % 6)
                0:
                begin
                    feed(CH_BACKSLASH);
                    do b = 8'($urandom_range(1, 255));
                    while (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                     CH_R, CH_T, CH_U});
                    feed(b);
                end
                1:
                begin
                    feed(CH_BACKSLASH);
                    feed(CH_U);
                    repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom_range(0, 15))));
                    do b = 8'($urandom_range(1, 255));
                    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                           (b >= 8'h61 && b <= 8'h66));
                    feed(b);
                end
                2: feed_hex_escape(16'($urandom_range(256, 65535)));
                3: feed(CH_NUL);
                4:
                begin
                    feed(CH_BACKSLASH);
                    feed(CH_NUL);
                end
                default:
                begin
                    feed(CH_BACKSLASH);
                    feed(CH_U);
                    repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom_range(0, 15))));
                    feed(CH_NUL);
                end
            endcase
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            int n;
            n = pick_gap();
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t observed;
        if (rst_n && out_valid && !out_stall)
        begin
            observed.kind = kind_t'(kind);
            observed.data_byte = data_byte;
            observed.error_code = err_t'(error_code);
            observed.decoded_count = decoded_count;
            observed.consumed_count = consumed_count;
            tracker.compare_output(observed);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
            $display("** json_string_unescaper: FAILED **");
            $finish;
        end
    end

    initial
    begin
        byte_list_t opening;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        fed = 0;
        stuck_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        opening = '{CH_NUL, 8'hFF,
                    CH_QUOTE, CH_QUOTE,
                    CH_QUOTE, 8'h01, 8'hFF, CH_BACKSLASH, CH_U, 8'h30, 8'h30, 8'h66,
                    8'h46, CH_QUOTE,
                    CH_QUOTE, CH_BACKSLASH, CH_U, 8'h30, 8'h31, 8'h30, 8'h30,
                    CH_QUOTE, CH_BACKSLASH, 8'h78,
                    CH_QUOTE, CH_BACKSLASH, CH_U, 8'h67,
                    CH_QUOTE, CH_NUL,
                    CH_QUOTE, CH_BACKSLASH, CH_NUL,
                    CH_QUOTE, CH_BACKSLASH, CH_U, 8'h39, CH_NUL};
        foreach (opening[i]) feed(opening[i]);
        drain();

        // A few strings sent without gaps on either side.
        idle_on = 1'b0;
        repeat (4) random_string();
        drain();
        idle_on = 1'b1;

        while (fed < 850)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    logic [7:0] b;
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE);
                    feed(b);
                end
            end
            else random_string();
            if ($urandom_range(0, 29) == 0) drain();
        end

        in_valid = 1'b0;
        while (tracker.pending_outputs.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("** json_string_unescaper: PASSED **");
        end
        else
        begin
            $display("** json_string_unescaper: FAILED **");
        end
        $finish;
    end

endmodule
